[design/dlta_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the sequencer control store for the tap averager.
package dlta_pkg;

  localparam int DELAY_DEPTH_DEF = 1024;
  localparam int DATA_W          = 32;
  localparam int ACC_W           = 40;
  localparam int CFG_W           = 8;
  localparam int DIV_STEPS       = ACC_W;
  localparam int DCNT_W          = $clog2(DIV_STEPS);
  localparam int PADDR_W         = 4;

  localparam logic [1:0] REG_APERTURE   = 2'd0;
  localparam logic [1:0] REG_TAP_OFFSET = 2'd1;
  localparam logic [1:0] REG_TAP_MODE   = 2'd2;

  typedef logic [2:0] step_t;

  localparam step_t ST_IDLE     = 3'd0;
  localparam step_t ST_WRITE    = 3'd1;
  localparam step_t ST_TAP      = 3'd2;
  localparam step_t ST_DRAIN    = 3'd3;
  localparam step_t ST_DIV_INIT = 3'd4;
  localparam step_t ST_DIV_STEP = 3'd5;
  localparam step_t ST_OUTPUT   = 3'd6;
  localparam step_t ST_RETURN   = 3'd7;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_WRITE,
    OP_TAP,
    OP_DRAIN,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_OUTPUT
  } dp_op_t;

  typedef enum logic [2:0] {
    BR_NEXT,
    BR_ALWAYS,
    BR_NO_INPUT,
    BR_NO_TAPS,
    BR_TAPS_LEFT,
    BR_DIV_LEFT,
    BR_OUT_BUSY
  } br_cond_t;

  typedef struct packed {
    dp_op_t   op;
    br_cond_t cond;
    step_t    target;
    logic     take_in;
  } uword_t;

  typedef struct packed {
    dp_op_t op;
    logic   accept;
  } dp_ctrl_t;

  typedef struct packed {
    logic clear_done;
    logic no_taps;
    logic taps_left;
    logic div_left;
    logic out_busy;
  } dp_status_t;

  typedef struct packed {
    logic [CFG_W-1:0] aperture;
    logic [CFG_W-1:0] tap_offset;
    logic             tap_mode;
  } cfg_t;

  function automatic uword_t ucode(input step_t s);
    uword_t w;
    case (s)
      ST_IDLE:     w = '{op: OP_LOAD,     cond: BR_NO_INPUT,  target: ST_IDLE,     take_in: 1'b1};
      ST_WRITE:    w = '{op: OP_WRITE,    cond: BR_NO_TAPS,   target: ST_DIV_INIT, take_in: 1'b0};
      ST_TAP:      w = '{op: OP_TAP,      cond: BR_TAPS_LEFT, target: ST_TAP,      take_in: 1'b0};
      ST_DRAIN:    w = '{op: OP_DRAIN,    cond: BR_NEXT,      target: ST_IDLE,     take_in: 1'b0};
      ST_DIV_INIT: w = '{op: OP_DIV_INIT, cond: BR_NEXT,      target: ST_IDLE,     take_in: 1'b0};
      ST_DIV_STEP: w = '{op: OP_DIV_STEP, cond: BR_DIV_LEFT,  target: ST_DIV_STEP, take_in: 1'b0};
      ST_OUTPUT:   w = '{op: OP_OUTPUT,   cond: BR_OUT_BUSY,  target: ST_OUTPUT,   take_in: 1'b0};
      default:     w = '{op: OP_NOP,      cond: BR_ALWAYS,    target: ST_IDLE,     take_in: 1'b0};
    endcase
    return w;
  endfunction

endpackage

[design/delay_line_tap_averager.sv]
`timescale 1ns / 1ps
// Delay-line tap averager, top level.
// Each sample is written to a circular history of DELAY_DEPTH words and averaged with
// 'aperture' earlier samples (contiguous or strided taps starting at tap_offset), the sum
// divided by aperture+1 with truncation toward zero. A microcoded sequencer walks the taps
// one memory read per cycle and then runs a restoring divider; a sample is taken only once
// the previous sample's result has been registered on the output. A result waiting on the
// output does not block the next sample until that sample's own result is ready.
// After reset the history is swept to zero, one word a cycle; samples are stalled during the
// sweep, register writes are taken throughout.
module delay_line_tap_averager #(
  parameter int DELAY_DEPTH = dlta_pkg::DELAY_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dlta_pkg::PADDR_W-1:0]        paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [dlta_pkg::DATA_W-1:0]  sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [dlta_pkg::DATA_W-1:0]  averaged
);
  import dlta_pkg::*;

  localparam int AW = $clog2(DELAY_DEPTH);

  cfg_t              cfg;
  dp_ctrl_t          ctrl;
  dp_status_t        status;
  logic              clear_done;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.aperture   <= CFG_W'(1);
      cfg.tap_offset <= CFG_W'(1);
      cfg.tap_mode   <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_APERTURE:   cfg.aperture   <= pwdata[CFG_W-1:0];
        REG_TAP_OFFSET: cfg.tap_offset <= pwdata[CFG_W-1:0];
        REG_TAP_MODE:   cfg.tap_mode   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_APERTURE:   prdata = 32'(cfg.aperture);
      REG_TAP_OFFSET: prdata = 32'(cfg.tap_offset);
      REG_TAP_MODE:   prdata = 32'(cfg.tap_mode);
      default:        prdata = '0;
    endcase
  end

  dlta_useq u_useq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .in_stall (in_stall),
    .ctrl     (ctrl)
  );

  dlta_dpath #(
    .DEPTH (DELAY_DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .cfg        (cfg),
    .sample     (sample),
    .clear_done (clear_done),
    .status     (status),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .out_valid  (out_valid),
    .averaged   (averaged),
    .out_stall  (out_stall)
  );

  dlta_store #(
    .DEPTH (DELAY_DEPTH)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .clear_done (clear_done)
  );

endmodule

[design/dlta_useq.sv]
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control store lookup and branch logic.
module dlta_useq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  dlta_pkg::dp_status_t  status,
  output logic                  in_stall,
  output dlta_pkg::dp_ctrl_t    ctrl
);
  import dlta_pkg::*;

  step_t  step;
  step_t  step_next;
  uword_t uw;
  logic   accept;
  logic   taken;

  assign uw = ucode(step);

  always_comb begin
    in_stall    = !(uw.take_in && status.clear_done);
    accept      = in_valid && !in_stall;
    ctrl.op     = uw.op;
    ctrl.accept = accept;
  end

  always_comb begin
    case (uw.cond)
      BR_NEXT:      taken = 1'b0;
      BR_ALWAYS:    taken = 1'b1;
      BR_NO_INPUT:  taken = !accept;
      BR_NO_TAPS:   taken = status.no_taps;
      BR_TAPS_LEFT: taken = status.taps_left;
      BR_DIV_LEFT:  taken = status.div_left;
      BR_OUT_BUSY:  taken = status.out_busy;
      default:      taken = 1'b1;
    endcase
    step_next = taken ? uw.target : step + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

[design/dlta_store.sv]
`timescale 1ns / 1ps
// Sample history memory with a clearing sweep after reset.
module dlta_store #(
  parameter int DEPTH = dlta_pkg::DELAY_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [$clog2(DEPTH)-1:0]    wr_addr,
  input  logic [dlta_pkg::DATA_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [$clog2(DEPTH)-1:0]    rd_addr,
  output logic [dlta_pkg::DATA_W-1:0] rd_data,
  output logic                        clear_done
);
  import dlta_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [AW-1:0]     clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      clear_done <= 1'b0;
    end else if (!clear_done) begin
      if (clr_addr == AW'(DEPTH - 1)) begin
        clear_done <= 1'b1;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!clear_done) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/dlta_dpath.sv]
`timescale 1ns / 1ps
// Datapath: pointers, tap address walk, accumulator, serial divider, output register.
module dlta_dpath #(
  parameter int DEPTH = dlta_pkg::DELAY_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  dlta_pkg::dp_ctrl_t          ctrl,
  input  dlta_pkg::cfg_t              cfg,
  input  logic [dlta_pkg::DATA_W-1:0] sample,
  input  logic                        clear_done,
  output dlta_pkg::dp_status_t        status,
  output logic                        wr_en,
  output logic [$clog2(DEPTH)-1:0]    wr_addr,
  output logic [dlta_pkg::DATA_W-1:0] wr_data,
  output logic                        rd_en,
  output logic [$clog2(DEPTH)-1:0]    rd_addr,
  input  logic [dlta_pkg::DATA_W-1:0] rd_data,
  output logic                        out_valid,
  output logic [dlta_pkg::DATA_W-1:0] averaged,
  input  logic                        out_stall
);
  import dlta_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int AW1  = AW + 1;
  localparam int RW   = (AW > CFG_W ? AW : CFG_W) + 1;
  localparam int REMW = CFG_W + 1;
  localparam int DIVW = REMW + 1;

  // config value modulo the depth; correct for values below five times the depth
  function automatic logic [AW-1:0] wrap_cfg(input logic [CFG_W-1:0] v);
    logic [RW-1:0] r;
    r = RW'(v);
    for (int k = 0; k < 4; k++) begin
      if (r >= RW'(DEPTH)) begin
        r = r - RW'(DEPTH);
      end
    end
    return r[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] sub_wrap(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] d;
    d = {1'b0, a} - {1'b0, b};
    if (d[AW]) begin
      d = d + AW1'(DEPTH);
    end
    return d[AW-1:0];
  endfunction

  logic [AW-1:0]     wp;
  logic [AW-1:0]     wp_inc;
  logic [AW-1:0]     raddr;
  logic [AW-1:0]     off_red;
  logic [AW-1:0]     stride_red;
  logic [CFG_W-1:0]  cnt;
  logic              pend;
  logic [DCNT_W-1:0] dcnt;
  logic [DATA_W-1:0] sample_r;
  logic [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]  rd_ext;
  logic [ACC_W-1:0]  quo;
  logic [REMW-1:0]   rem;
  logic              neg;
  logic [DIVW-1:0]   sh;
  logic [DIVW-1:0]   dvs;
  logic [DIVW-1:0]   diff;
  logic              fits;
  logic              out_free;

  always_comb begin
    off_red    = wrap_cfg(cfg.tap_offset);
    stride_red = cfg.tap_mode ? wrap_cfg(cfg.aperture) : AW'(1);
    wp_inc     = (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
    rd_ext     = {{(ACC_W - DATA_W){rd_data[DATA_W-1]}}, rd_data};
    sh         = {rem, quo[ACC_W-1]};
    dvs        = DIVW'(cfg.aperture) + DIVW'(1);
    diff       = sh - dvs;
    fits       = (sh >= dvs);
    out_free   = !out_valid || !out_stall;
  end

  always_comb begin
    wr_en   = (ctrl.op == OP_WRITE);
    wr_addr = wp;
    wr_data = sample_r;
    rd_en   = (ctrl.op == OP_TAP);
    rd_addr = raddr;
  end

  always_comb begin
    status.clear_done = clear_done;
    status.no_taps    = (cfg.aperture == '0);
    status.taps_left  = (cnt > CFG_W'(1));
    status.div_left   = (dcnt != '0);
    status.out_busy   = !out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp        <= '0;
      cnt       <= '0;
      pend      <= 1'b0;
      dcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.op == OP_OUTPUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (ctrl.op)
        OP_LOAD: begin
          if (ctrl.accept) begin
            wp <= wp_inc;
          end
        end
        OP_WRITE: begin
          cnt  <= cfg.aperture;
          pend <= 1'b0;
        end
        OP_TAP: begin
          cnt  <= cnt - 1'b1;
          pend <= 1'b1;
        end
        OP_DIV_INIT: dcnt <= DCNT_W'(DIV_STEPS - 1);
        OP_DIV_STEP: dcnt <= dcnt - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: begin
        if (ctrl.accept) begin
          sample_r <= sample;
        end
      end
      OP_WRITE: begin
        acc   <= {{(ACC_W - DATA_W){sample_r[DATA_W-1]}}, sample_r};
        raddr <= sub_wrap(wp, off_red);
      end
      OP_TAP: begin
        raddr <= sub_wrap(raddr, stride_red);
        if (pend) begin
          acc <= acc + rd_ext;
        end
      end
      OP_DRAIN: acc <= acc + rd_ext;
      OP_DIV_INIT: begin
        neg <= acc[ACC_W-1];
        quo <= acc[ACC_W-1] ? ACC_W'(0) - acc : acc;
        rem <= '0;
      end
      OP_DIV_STEP: begin
        rem <= fits ? diff[REMW-1:0] : sh[REMW-1:0];
        quo <= {quo[ACC_W-2:0], fits};
      end
      OP_OUTPUT: begin
        if (out_free) begin
          averaged <= neg ? DATA_W'(0) - quo[DATA_W-1:0] : quo[DATA_W-1:0];
        end
      end
      default: ;
    endcase
  end

endmodule

[design/dlta_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the tap averager, bound to the top level.
module dlta_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        pready,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [dlta_pkg::DATA_W-1:0] averaged
);
  import dlta_pkg::*;

  // history sweep starts after reset: no samples, no results
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> in_stall && !out_valid)
    else $error("samples taken or result shown right after reset");

  // one sample in work at a time
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second sample taken straight after a beat");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(averaged))
    else $error("stalled result changed or dropped");

  a_pready: assert property (@(posedge clk)
    pready)
    else $error("register port not ready");

endmodule

bind delay_line_tap_averager dlta_checker u_dlta_checker (
  .clk       (clk),
  .rst       (rst),
  .pready    (pready),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .averaged  (averaged)
);
